>>> sv/lbd_pkg.sv
package lbd_pkg;

    // Fixed widths of the stream fields
    localparam int EDGE_W    = 14;
    localparam int CHAN_W    = 8;
    localparam int SHIFT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 14;

    // Register reset values
    localparam logic [CFG_DAT_W-1:0] RESET_FRAME_WIDTH  = 14'd1920;
    localparam logic [CFG_DAT_W-1:0] RESET_FRAME_HEIGHT = 14'd1080;
    localparam logic [SHIFT_W-1:0]   RESET_DARK_SHIFT   = 3'd2;

    // Register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_DARK_SHIFT   = 2'd2
    } cfg_reg_t;

    // Word kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // floor(n / 10) == (n * 52429) >> 19 for every n below 43699
    localparam int DIV10_MUL_W = 16;
    localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
    localparam int DIV10_SHIFT = 19;

    // Sample lines sit at k * (dim / 10) for k in this range
    localparam int SAMPLE_K_LO = 2;
    localparam int SAMPLE_K_HI = 9;

    // Event handed from the scan stage to the merge stage
    typedef struct packed {
        logic clear;        // drop the accumulated bounds
        logic top_found;    // a bright row above the middle was seen
        logic bottom_found; // a bright row below the middle was seen
        logic left_found;   // a bright column left of the middle was seen
        logic right_found;  // a bright column right of the middle was seen
    } evt_flags_t;

endpackage

>>> sv/lbd_scan.sv
module lbd_scan
    import lbd_pkg::*;
#(
    parameter int MAX_DIM = 8192
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 kind,
    input  logic [CHAN_W-1:0]                    red,
    input  logic [CHAN_W-1:0]                    green,
    input  logic [CHAN_W-1:0]                    blue,
    input  logic                                 frame_start,
    input  logic [$clog2(MAX_DIM+1)-1:0]         frame_w,
    input  logic [$clog2(MAX_DIM+1)-1:0]         frame_h,
    input  logic [$clog2(MAX_DIM+1)-1:0]         step_w,
    input  logic [$clog2(MAX_DIM+1)-1:0]         step_h,
    input  logic [SHIFT_W-1:0]                   shift,
    output logic                                 evt_valid,
    input  logic                                 evt_ready,
    output evt_flags_t                           evt_flags,
    output logic [$clog2(MAX_DIM)-1:0]           evt_top_row,
    output logic [$clog2(MAX_DIM)-1:0]           evt_bottom_row,
    output logic [$clog2(MAX_DIM)-1:0]           evt_left_col,
    output logic [$clog2(MAX_DIM)-1:0]           evt_right_col,
    output logic [$clog2(MAX_DIM+1)-1:0]         evt_w,
    output logic [$clog2(MAX_DIM+1)-1:0]         evt_h
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int MARK_W = DIM_W + 4;

    // input word register
    logic              s_valid_reg;
    logic              s_kind_reg;
    logic [CHAN_W-1:0] s_red_reg;
    logic [CHAN_W-1:0] s_green_reg;
    logic [CHAN_W-1:0] s_blue_reg;
    logic              s_start_reg;

    // raster position and per-frame finds
    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [POS_W-1:0] fbr_reg, fbr_next;
    logic [POS_W-1:0] lbr_reg, lbr_next;
    logic [POS_W-1:0] fbc_reg, fbc_next;
    logic [POS_W-1:0] lbc_reg, lbc_next;
    logic             fbr_ok_reg, fbr_ok_next;
    logic             lbr_ok_reg, lbr_ok_next;
    logic             fbc_ok_reg, fbc_ok_next;
    logic             lbc_ok_reg, lbc_ok_next;

    // event register
    logic              evt_valid_reg;
    evt_flags_t        evt_flags_reg, evt_flags_next;
    logic [POS_W-1:0]  evt_top_reg, evt_bottom_reg, evt_left_reg, evt_right_reg;
    logic [DIM_W-1:0]  evt_w_reg, evt_h_reg;

    logic             s_fire;
    logic             needs_evt;
    logic             is_pixel;
    logic             bright;
    logic             col_sampled;
    logic             row_sampled;
    logic             line_end;
    logic             frame_end;
    logic [POS_W-1:0] c, y;
    logic [POS_W-1:0] fbr_base, lbr_base, fbc_base, lbc_base;
    logic             fbr_ok_base, lbr_ok_base, fbc_ok_base, lbc_ok_base;
    logic [DIM_W-1:0] half_w, half_h;
    logic [DIM_W-1:0] c_inc, y_inc;

    // position lies on one of the sample lines k*step; with a zero step only 0 counts
    function automatic logic is_sample(input logic [POS_W-1:0] pos,
                                       input logic [DIM_W-1:0] step);
        logic              hit;
        logic [MARK_W-1:0] mark;
        hit  = 1'b0;
        mark = '0;
        if (step == '0) begin
            hit = (pos == '0);
        end
        else begin
            for (int k = SAMPLE_K_LO; k <= SAMPLE_K_HI; k++) begin
                mark = MARK_W'(step) * MARK_W'(k);
                hit  = hit | (MARK_W'(pos) == mark);
            end
        end
        return hit;
    endfunction

    assign is_pixel = (s_kind_reg == KIND_PIXEL);
    assign half_w   = frame_w >> 1;
    assign half_h   = frame_h >> 1;

    always_comb
    begin
        // frame start restarts the raster and the finds before the pixel counts
        c           = s_start_reg ? '0   : col_reg;
        y           = s_start_reg ? '0   : row_reg;
        fbr_base    = s_start_reg ? '0   : fbr_reg;
        lbr_base    = s_start_reg ? '0   : lbr_reg;
        fbc_base    = s_start_reg ? '0   : fbc_reg;
        lbc_base    = s_start_reg ? '0   : lbc_reg;
        fbr_ok_base = s_start_reg ? 1'b0 : fbr_ok_reg;
        lbr_ok_base = s_start_reg ? 1'b0 : lbr_ok_reg;
        fbc_ok_base = s_start_reg ? 1'b0 : fbc_ok_reg;
        lbc_ok_base = s_start_reg ? 1'b0 : lbc_ok_reg;

        bright = |{s_red_reg >> shift, s_green_reg >> shift, s_blue_reg >> shift};
        col_sampled = bright && is_sample(c, step_w);
        row_sampled = bright && is_sample(y, step_h);

        fbr_next    = fbr_base;
        lbr_next    = lbr_base;
        fbc_next    = fbc_base;
        lbc_next    = lbc_base;
        fbr_ok_next = fbr_ok_base;
        lbr_ok_next = lbr_ok_base;
        fbc_ok_next = fbc_ok_base;
        lbc_ok_next = lbc_ok_base;

        if (col_sampled && (DIM_W'(y) < half_h) && !fbr_ok_base) begin
            fbr_next    = y;
            fbr_ok_next = 1'b1;
        end
        if (col_sampled && (DIM_W'(y) > half_h)) begin
            lbr_next    = y;
            lbr_ok_next = 1'b1;
        end
        if (row_sampled && (DIM_W'(c) < half_w) && (!fbc_ok_base || c < fbc_base)) begin
            fbc_next    = c;
            fbc_ok_next = 1'b1;
        end
        if (row_sampled && (DIM_W'(c) > half_w) && (!lbc_ok_base || c > lbc_base)) begin
            lbc_next    = c;
            lbc_ok_next = 1'b1;
        end

        // a column at or past the width (size shrunk) wraps at once; a row past the height wraps at the line end
        c_inc     = DIM_W'(c) + DIM_W'(1);
        y_inc     = DIM_W'(y) + DIM_W'(1);
        line_end  = !(c_inc < frame_w);
        frame_end = line_end && !(y_inc < frame_h);

        col_next = line_end ? '0 : POS_W'(c_inc);
        if (!line_end) begin
            row_next = y;
        end
        else if (frame_end) begin
            row_next = '0;
        end
        else begin
            row_next = POS_W'(y_inc);
        end

        evt_flags_next.clear        = !is_pixel;
        evt_flags_next.top_found    = fbr_ok_next;
        evt_flags_next.bottom_found = lbr_ok_next;
        evt_flags_next.left_found   = fbc_ok_next;
        evt_flags_next.right_found  = lbc_ok_next;
    end

    assign needs_evt = !is_pixel || frame_end;
    assign s_fire    = s_valid_reg && (!needs_evt || !evt_valid_reg || evt_ready);
    assign in_ready  = !s_valid_reg || s_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            s_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            s_kind_reg  <= kind;
            s_red_reg   <= red;
            s_green_reg <= green;
            s_blue_reg  <= blue;
            s_start_reg <= frame_start;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            col_reg    <= '0;
            row_reg    <= '0;
            fbr_reg    <= '0;
            lbr_reg    <= '0;
            fbc_reg    <= '0;
            lbc_reg    <= '0;
            fbr_ok_reg <= 1'b0;
            lbr_ok_reg <= 1'b0;
            fbc_ok_reg <= 1'b0;
            lbc_ok_reg <= 1'b0;
        end
        else if (s_fire && is_pixel) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (frame_end) begin
                fbr_reg    <= '0;
                lbr_reg    <= '0;
                fbc_reg    <= '0;
                lbc_reg    <= '0;
                fbr_ok_reg <= 1'b0;
                lbr_ok_reg <= 1'b0;
                fbc_ok_reg <= 1'b0;
                lbc_ok_reg <= 1'b0;
            end
            else begin
                fbr_reg    <= fbr_next;
                lbr_reg    <= lbr_next;
                fbc_reg    <= fbc_next;
                lbc_reg    <= lbc_next;
                fbr_ok_reg <= fbr_ok_next;
                lbr_ok_reg <= lbr_ok_next;
                fbc_ok_reg <= fbc_ok_next;
                lbc_ok_reg <= lbc_ok_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            evt_valid_reg <= 1'b0;
        end
        else if (s_fire && needs_evt) begin
            evt_valid_reg <= 1'b1;
        end
        else if (evt_ready) begin
            evt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire && needs_evt) begin
            evt_flags_reg  <= evt_flags_next;
            evt_top_reg    <= fbr_next;
            evt_bottom_reg <= lbr_next;
            evt_left_reg   <= fbc_next;
            evt_right_reg  <= lbc_next;
            evt_w_reg      <= frame_w;
            evt_h_reg      <= frame_h;
        end
    end

    assign evt_valid      = evt_valid_reg;
    assign evt_flags      = evt_flags_reg;
    assign evt_top_row    = evt_top_reg;
    assign evt_bottom_row = evt_bottom_reg;
    assign evt_left_col   = evt_left_reg;
    assign evt_right_col  = evt_right_reg;
    assign evt_w          = evt_w_reg;
    assign evt_h          = evt_h_reg;

endmodule

>>> sv/lbd_merge.sv
module lbd_merge
    import lbd_pkg::*;
#(
    parameter int MAX_DIM = 8192
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         evt_valid,
    output logic                         evt_ready,
    input  evt_flags_t                   evt_flags,
    input  logic [$clog2(MAX_DIM)-1:0]   evt_top_row,
    input  logic [$clog2(MAX_DIM)-1:0]   evt_bottom_row,
    input  logic [$clog2(MAX_DIM)-1:0]   evt_left_col,
    input  logic [$clog2(MAX_DIM)-1:0]   evt_right_col,
    input  logic [$clog2(MAX_DIM+1)-1:0] evt_w,
    input  logic [$clog2(MAX_DIM+1)-1:0] evt_h,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [EDGE_W-1:0]            left_edge,
    output logic [EDGE_W-1:0]            right_edge,
    output logic [EDGE_W-1:0]            top_edge,
    output logic [EDGE_W-1:0]            bottom_edge
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    logic [DIM_W-1:0] acc_left_reg, acc_left_next;
    logic [DIM_W-1:0] acc_right_reg, acc_right_next;
    logic [DIM_W-1:0] acc_top_reg, acc_top_next;
    logic [DIM_W-1:0] acc_bottom_reg, acc_bottom_next;
    logic             left_ok_reg, right_ok_reg, top_ok_reg, bottom_ok_reg;

    logic              out_valid_reg;
    logic [EDGE_W-1:0] left_reg, right_reg, top_reg, bottom_reg;

    logic [DIM_W-1:0] half_w, half_h;
    logic [DIM_W-1:0] top_cand, bottom_cand, left_cand, right_cand;
    logic             evt_fire;

    // edge candidates one line next to the outer frame border are rejected
    function automatic logic allowed(input logic [DIM_W-1:0] cand,
                                     input logic [DIM_W-1:0] dim);
        return (cand != DIM_W'(1)) && ((DIM_W+1)'(cand) + (DIM_W+1)'(2) != (DIM_W+1)'(dim));
    endfunction

    assign half_w = evt_w >> 1;
    assign half_h = evt_h >> 1;

    always_comb
    begin
        top_cand    = evt_flags.top_found    ? DIM_W'(evt_top_row) + DIM_W'(1)    : half_h;
        bottom_cand = evt_flags.bottom_found ? DIM_W'(evt_bottom_row) - DIM_W'(1) : half_h;
        left_cand   = evt_flags.left_found   ? DIM_W'(evt_left_col) + DIM_W'(1)   : half_w;
        right_cand  = evt_flags.right_found  ? DIM_W'(evt_right_col) - DIM_W'(1)  : half_w;

        // merge, then fill anything still unset with the full-frame default
        if (allowed(top_cand, evt_h) && (!top_ok_reg || top_cand < acc_top_reg)) begin
            acc_top_next = top_cand;
        end
        else if (top_ok_reg) begin
            acc_top_next = acc_top_reg;
        end
        else begin
            acc_top_next = '0;
        end

        if (allowed(bottom_cand, evt_h) && (!bottom_ok_reg || bottom_cand > acc_bottom_reg)) begin
            acc_bottom_next = bottom_cand;
        end
        else if (bottom_ok_reg) begin
            acc_bottom_next = acc_bottom_reg;
        end
        else begin
            acc_bottom_next = evt_h;
        end

        if (allowed(left_cand, evt_w) && (!left_ok_reg || left_cand < acc_left_reg)) begin
            acc_left_next = left_cand;
        end
        else if (left_ok_reg) begin
            acc_left_next = acc_left_reg;
        end
        else begin
            acc_left_next = '0;
        end

        if (allowed(right_cand, evt_w) && (!right_ok_reg || right_cand > acc_right_reg)) begin
            acc_right_next = right_cand;
        end
        else if (right_ok_reg) begin
            acc_right_next = acc_right_reg;
        end
        else begin
            acc_right_next = evt_w;
        end
    end

    // clears never wait; a frame result waits for a free output register
    assign evt_ready = evt_flags.clear || !out_valid_reg || out_ready;
    assign evt_fire  = evt_valid && evt_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_ok_reg   <= 1'b0;
            right_ok_reg  <= 1'b0;
            top_ok_reg    <= 1'b0;
            bottom_ok_reg <= 1'b0;
        end
        else if (evt_fire) begin
            left_ok_reg   <= !evt_flags.clear;
            right_ok_reg  <= !evt_flags.clear;
            top_ok_reg    <= !evt_flags.clear;
            bottom_ok_reg <= !evt_flags.clear;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_fire && !evt_flags.clear) begin
            acc_left_reg   <= acc_left_next;
            acc_right_reg  <= acc_right_next;
            acc_top_reg    <= acc_top_next;
            acc_bottom_reg <= acc_bottom_next;
            left_reg       <= EDGE_W'(acc_left_next);
            right_reg      <= EDGE_W'(acc_right_next);
            top_reg        <= EDGE_W'(acc_top_next);
            bottom_reg     <= EDGE_W'(acc_bottom_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (evt_fire && !evt_flags.clear) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_edge   = left_reg;
    assign right_edge  = right_reg;
    assign top_edge    = top_reg;
    assign bottom_edge = bottom_reg;

endmodule

>>> sv/letterbox_border_detector.sv
// Throughput: one word per cycle, pixels and clear words alike, while out_ready does not hold back a result.
// A frame's crop window shows on out_valid once its last pixel has passed the input, event and output registers.
// Pipeline: input register -> scan (raster counters, finds) -> event register -> merge -> output.
// Reset (async, active low): size 1920 x 1080, dark_shift 2, raster at 0, no finds,
// all four accumulated bounds unset. No clearing pass.
module letterbox_border_detector
    import lbd_pkg::*;
#(
    parameter int MAX_DIM = 8192
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // pixel / control words
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 kind,
    input  logic [CHAN_W-1:0]    red,
    input  logic [CHAN_W-1:0]    green,
    input  logic [CHAN_W-1:0]    blue,
    input  logic                 frame_start,
    // crop window words
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [EDGE_W-1:0]    left_edge,
    output logic [EDGE_W-1:0]    right_edge,
    output logic [EDGE_W-1:0]    top_edge,
    output logic [EDGE_W-1:0]    bottom_edge,
    // register writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int CMP_W  = (DIM_W > CFG_DAT_W) ? DIM_W : CFG_DAT_W;
    localparam int PROD_W = DIM_W + DIV10_MUL_W;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

    // Raw registers as written over the register port.
    logic [CFG_DAT_W-1:0] width_reg;
    logic [CFG_DAT_W-1:0] height_reg;
    logic [SHIFT_W-1:0]   shift_reg;

    // Derived geometry, re-registered every cycle from the raw registers. Writes must only
    // land while the pipe is empty, a rule for the user that the block does not enforce. A word
    // taken right after a write reaches the scan logic from the input register, when these hold the new size.
    logic [DIM_W-1:0] frame_w_reg, frame_w_next;
    logic [DIM_W-1:0] frame_h_reg, frame_h_next;
    logic [DIM_W-1:0] step_w_reg, step_w_next;
    logic [DIM_W-1:0] step_h_reg, step_h_next;

    logic [PROD_W-1:0] prod_w, prod_h;

    // scan -> merge
    logic              evt_valid;
    logic              evt_ready;
    evt_flags_t        evt_flags;
    logic [POS_W-1:0]  evt_top_row, evt_bottom_row, evt_left_col, evt_right_col;
    logic [DIM_W-1:0]  evt_w, evt_h;

    // sizes are held to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DAT_W-1:0] raw);
        logic [CMP_W-1:0] v;
        v = CMP_W'(raw);
        if (v == '0) begin
            v = CMP_W'(1);
        end
        else if (v > MAX_DIM_C) begin
            v = MAX_DIM_C;
        end
        return DIM_W'(v);
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            width_reg  <= RESET_FRAME_WIDTH;
            height_reg <= RESET_FRAME_HEIGHT;
            shift_reg  <= RESET_DARK_SHIFT;
        end
        else if (cfg_valid && cfg_ready) begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                CFG_DARK_SHIFT:   shift_reg  <= cfg_data[SHIFT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sample spacing = size / 10 by reciprocal multiply.
    always_comb
    begin
        frame_w_next = clamp_dim(width_reg);
        frame_h_next = clamp_dim(height_reg);
        prod_w       = PROD_W'(frame_w_next) * PROD_W'(DIV10_MUL);
        prod_h       = PROD_W'(frame_h_next) * PROD_W'(DIV10_MUL);
        step_w_next  = DIM_W'(prod_w >> DIV10_SHIFT);
        step_h_next  = DIM_W'(prod_h >> DIV10_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        frame_w_reg <= frame_w_next;
        frame_h_reg <= frame_h_next;
        step_w_reg  <= step_w_next;
        step_h_reg  <= step_h_next;
    end

    // Raster tracking and per-frame bright row / column search.
    lbd_scan #(
        .MAX_DIM (MAX_DIM)
    ) u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .frame_start    (frame_start),
        .frame_w        (frame_w_reg),
        .frame_h        (frame_h_reg),
        .step_w         (step_w_reg),
        .step_h         (step_h_reg),
        .shift          (shift_reg),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .evt_flags      (evt_flags),
        .evt_top_row    (evt_top_row),
        .evt_bottom_row (evt_bottom_row),
        .evt_left_col   (evt_left_col),
        .evt_right_col  (evt_right_col),
        .evt_w          (evt_w),
        .evt_h          (evt_h)
    );

    // Cross-frame min/max accumulation and the output word register.
    lbd_merge #(
        .MAX_DIM (MAX_DIM)
    ) u_merge (
        .clk            (clk),
        .rst_n          (rst_n),
        .evt_valid      (evt_valid),
        .evt_ready      (evt_ready),
        .evt_flags      (evt_flags),
        .evt_top_row    (evt_top_row),
        .evt_bottom_row (evt_bottom_row),
        .evt_left_col   (evt_left_col),
        .evt_right_col  (evt_right_col),
        .evt_w          (evt_w),
        .evt_h          (evt_h),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_edge      (left_edge),
        .right_edge     (right_edge),
        .top_edge       (top_edge),
        .bottom_edge    (bottom_edge)
    );

endmodule
